// ===== rtl/core/u8u16_pkg.sv =====
package u8u16_pkg;

	localparam int BYTE_W     = 8;
	localparam int UNIT_W     = 16;
	localparam int CP_W       = 21;
	localparam int COUNT_BITS = 16;
	localparam int CMP_W      = 33;

	localparam logic [UNIT_W-1:0] CAP_RESET = 16'hFFFF;

	// end report status codes
	localparam logic [1:0] ST_NORMAL    = 2'd0;
	localparam logic [1:0] ST_MALFORMED = 2'd1;
	localparam logic [1:0] ST_TRUNCATED = 2'd2;
	localparam logic [1:0] ST_CAPACITY  = 2'd3;

	// lead and continuation byte limits
	localparam logic [BYTE_W-1:0] ASCII_MAX  = 8'h7F;
	localparam logic [BYTE_W-1:0] LEAD2_MIN  = 8'hC2;
	localparam logic [BYTE_W-1:0] LEAD2_MAX  = 8'hDF;
	localparam logic [BYTE_W-1:0] LEAD3_MIN  = 8'hE0;
	localparam logic [BYTE_W-1:0] LEAD3_MAX  = 8'hEF;
	localparam logic [BYTE_W-1:0] LEAD4_MIN  = 8'hF0;
	localparam logic [BYTE_W-1:0] LEAD4_MAX  = 8'hF4;
	localparam logic [BYTE_W-1:0] CONT_MIN   = 8'h80;
	localparam logic [BYTE_W-1:0] CONT_MAX   = 8'hBF;
	localparam logic [BYTE_W-1:0] LEAD_ED    = 8'hED;
	localparam logic [BYTE_W-1:0] E0_CONT_MIN = 8'hA0;
	localparam logic [BYTE_W-1:0] ED_CONT_MAX = 8'h9F;
	localparam logic [BYTE_W-1:0] F0_CONT_MIN = 8'h90;
	localparam logic [BYTE_W-1:0] F4_CONT_MAX = 8'h8F;

	localparam logic [CP_W-1:0]   BMP_MAX    = 21'h00FFFF;
	localparam logic [CP_W-1:0]   SUPP_BASE  = 21'h010000;
	localparam logic [UNIT_W-1:0] HI_SURR    = 16'hD800;
	localparam logic [UNIT_W-1:0] LO_SURR    = 16'hDC00;

	// job queue between front and back
	localparam int JQ_DEPTH = 4;
	localparam int JQ_AW    = $clog2(JQ_DEPTH);
	localparam int JQ_CW    = $clog2(JQ_DEPTH + 1);

	typedef struct packed {
		logic [UNIT_W-1:0] unit0;
		logic [UNIT_W-1:0] unit1;
		logic [UNIT_W-1:0] count0;
		logic [UNIT_W-1:0] count_final;
		logic [1:0]        n_units;
		logic              report;
		logic [1:0]        status;
		logic              term_fits;
	} job_t;

endpackage

// ===== rtl/core/u8u16_front.sv =====
module u8u16_front
	import u8u16_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              accept,
	input  logic [BYTE_W-1:0] data_byte,
	input  logic              end_of_string,
	input  logic              cfg_wr_en,
	input  logic [UNIT_W-1:0] cfg_wr_data,
	output logic              job_valid,
	output job_t              job
);

	logic                  stopped_q;
	logic [1:0]            reason_q;
	logic [2:0]            exp_q;
	logic [2:0]            seen_q;
	logic [BYTE_W-1:0]     lead_q;
	logic [CP_W-1:0]       cp_q;
	logic [COUNT_BITS-1:0] uw_q;
	logic [UNIT_W-1:0]     cap_q;

	logic                  n_stopped;
	logic [1:0]            n_reason;
	logic [2:0]            n_exp;
	logic [2:0]            n_seen;
	logic [BYTE_W-1:0]     n_lead;
	logic [CP_W-1:0]       n_cp;
	logic [COUNT_BITS-1:0] n_uw;

	logic                  fin;
	logic                  bad;
	logic                  need2;
	logic [COUNT_BITS:0]   sum;
	logic [CP_W-1:0]       v;
	logic                  is_end;
	logic [2:0]            seen_inc;

	always_comb begin
		n_stopped = stopped_q;
		n_reason  = reason_q;
		n_exp     = exp_q;
		n_seen    = seen_q;
		n_lead    = lead_q;
		n_cp      = cp_q;
		n_uw      = uw_q;
		fin       = 1'b0;
		bad       = 1'b0;
		job       = '0;
		is_end    = (data_byte == '0) || end_of_string;
		seen_inc  = seen_q + 3'd1;

		if (data_byte != '0 && !stopped_q) begin
			if (seen_q == 3'd0) begin
				if (data_byte <= ASCII_MAX) begin
					n_exp = 3'd1;
					n_cp  = CP_W'(data_byte);
				end else if (data_byte >= LEAD2_MIN && data_byte <= LEAD2_MAX) begin
					n_exp = 3'd2;
					n_cp  = CP_W'(data_byte[4:0]);
				end else if (data_byte >= LEAD3_MIN && data_byte <= LEAD3_MAX) begin
					n_exp = 3'd3;
					n_cp  = CP_W'(data_byte[3:0]);
				end else if (data_byte >= LEAD4_MIN && data_byte <= LEAD4_MAX) begin
					n_exp = 3'd4;
					n_cp  = CP_W'(data_byte[2:0]);
				end else begin
					bad = 1'b1;
				end
				if (!bad) begin
					n_lead = data_byte;
					n_seen = 3'd1;
					fin    = (data_byte <= ASCII_MAX);
				end
			end else begin
				bad = (data_byte < CONT_MIN) || (data_byte > CONT_MAX) ||
					((seen_q == 3'd1) &&
					 ((lead_q == LEAD3_MIN && data_byte < E0_CONT_MIN) ||
					  (lead_q == LEAD_ED && data_byte > ED_CONT_MAX) ||
					  (lead_q == LEAD4_MIN && data_byte < F0_CONT_MIN) ||
					  (lead_q == LEAD4_MAX && data_byte > F4_CONT_MAX)));
				if (!bad) begin
					n_cp   = {cp_q[CP_W-7:0], data_byte[5:0]};
					n_seen = seen_inc;
					fin    = (seen_inc >= exp_q);
				end
			end
			if (bad) begin
				n_stopped = 1'b1;
				n_reason  = ST_MALFORMED;
				n_exp     = '0;
				n_seen    = '0;
				n_lead    = '0;
				n_cp      = '0;
			end
		end

		need2 = (n_cp > BMP_MAX);
		sum   = {1'b0, uw_q} + (COUNT_BITS+1)'(need2 ? 2 : 1);
		v     = n_cp - SUPP_BASE;

		if (fin) begin
			// the count after the new units must stay below capacity
			if (CMP_W'(sum) >= CMP_W'(cap_q) || sum[COUNT_BITS]) begin
				n_stopped = 1'b1;
				n_reason  = ST_CAPACITY;
			end else begin
				n_uw            = sum[COUNT_BITS-1:0];
				job.n_units     = need2 ? 2'd2 : 2'd1;
				job.unit0       = need2 ? (HI_SURR + UNIT_W'(v[19:10])) : n_cp[UNIT_W-1:0];
				job.unit1       = LO_SURR + UNIT_W'(v[9:0]);
				job.count0      = UNIT_W'(uw_q + COUNT_BITS'(1));
				job.count_final = UNIT_W'(sum[COUNT_BITS-1:0]);
			end
			n_exp  = '0;
			n_seen = '0;
			n_lead = '0;
			n_cp   = '0;
		end

		if (is_end) begin
			if (!n_stopped && n_seen != 3'd0) begin
				n_stopped = 1'b1;
				n_reason  = ST_TRUNCATED;
			end
			job.report      = 1'b1;
			job.status      = n_stopped ? n_reason : ST_NORMAL;
			job.term_fits   = (cap_q != '0);
			job.count_final = UNIT_W'(n_uw);
			n_stopped = 1'b0;
			n_reason  = ST_NORMAL;
			n_exp     = '0;
			n_seen    = '0;
			n_lead    = '0;
			n_cp      = '0;
			n_uw      = '0;
		end

		job_valid = accept && ((job.n_units != 2'd0) || job.report);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stopped_q <= 1'b0;
			reason_q  <= ST_NORMAL;
			exp_q     <= '0;
			seen_q    <= '0;
			lead_q    <= '0;
			cp_q      <= '0;
			uw_q      <= '0;
		end else if (accept) begin
			stopped_q <= n_stopped;
			reason_q  <= n_reason;
			exp_q     <= n_exp;
			seen_q    <= n_seen;
			lead_q    <= n_lead;
			cp_q      <= n_cp;
			uw_q      <= n_uw;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAP_RESET;
		end else if (cfg_wr_en) begin
			cap_q <= cfg_wr_data;
		end
	end

endmodule

// ===== rtl/core/u8u16_jobq.sv =====
module u8u16_jobq
	import u8u16_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic wr_en,
	input  job_t wr_job,
	output logic full,
	input  logic rd_en,
	output logic head_valid,
	output job_t head_job
);

	job_t             mem_q [JQ_DEPTH];
	logic [JQ_AW-1:0] wr_ptr_q;
	logic [JQ_AW-1:0] rd_ptr_q;
	logic [JQ_CW-1:0] cnt_q;

	assign full       = (cnt_q == JQ_CW'(JQ_DEPTH));
	assign head_valid = (cnt_q != '0);
	assign head_job   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= wr_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= (wr_ptr_q == JQ_AW'(JQ_DEPTH - 1)) ? '0 : wr_ptr_q + JQ_AW'(1);
			end
			if (rd_en) begin
				rd_ptr_q <= (rd_ptr_q == JQ_AW'(JQ_DEPTH - 1)) ? '0 : rd_ptr_q + JQ_AW'(1);
			end
			if (wr_en && !rd_en) begin
				cnt_q <= cnt_q + JQ_CW'(1);
			end else if (rd_en && !wr_en) begin
				cnt_q <= cnt_q - JQ_CW'(1);
			end
		end
	end

endmodule

// ===== rtl/core/u8u16_back.sv =====
module u8u16_back
	import u8u16_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              head_valid,
	input  job_t              head_job,
	output logic              head_pop,
	input  logic              pop,
	output logic              empty,
	output logic [UNIT_W-1:0] code_unit,
	output logic              is_end_report,
	output logic [UNIT_W-1:0] unit_count,
	output logic [1:0]        end_status,
	output logic              terminator_fits,
	output logic              last
);

	logic [1:0]        idx_q;
	logic              out_valid_q;
	logic [UNIT_W-1:0] unit_q;
	logic              rep_q;
	logic [UNIT_W-1:0] count_q;
	logic [1:0]        status_q;
	logic              fits_q;
	logic              last_q;

	logic              load;
	logic [1:0]        total;
	logic              cur_last;
	logic [UNIT_W-1:0] cur_unit;
	logic [UNIT_W-1:0] cur_count;
	logic              cur_rep;

	always_comb begin
		load     = head_valid && (!out_valid_q || pop);
		total    = head_job.n_units + {1'b0, head_job.report};
		cur_last = (idx_q == total - 2'd1);
		cur_rep  = (idx_q >= head_job.n_units);
		// units come first, then the report if the item carries one
		if (cur_rep) begin
			cur_unit  = '0;
			cur_count = head_job.count_final;
		end else if (idx_q == 2'd0) begin
			cur_unit  = head_job.unit0;
			cur_count = head_job.count0;
		end else begin
			cur_unit  = head_job.unit1;
			cur_count = head_job.count_final;
		end
		head_pop = load && cur_last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
				idx_q       <= cur_last ? 2'd0 : idx_q + 2'd1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			unit_q   <= cur_unit;
			rep_q    <= cur_rep;
			count_q  <= cur_count;
			status_q <= cur_rep ? head_job.status : ST_NORMAL;
			fits_q   <= cur_rep && head_job.term_fits;
			last_q   <= cur_last;
		end
	end

	assign empty           = !out_valid_q;
	assign code_unit       = unit_q;
	assign is_end_report   = rep_q;
	assign unit_count      = count_q;
	assign end_status      = status_q;
	assign terminator_fits = fits_q;
	assign last            = last_q;

endmodule

// ===== rtl/core/utf8_to_utf16_transcoder_unit.sv =====
// utf-8 to utf-16 transcoder, one byte in per cycle while full is low
// input side is a queue write port: data_byte and end_of_string are taken at a
// clock edge with push high and full low. a zero byte or a flagged byte ends the
// string and produces an end report after any code units of that byte
// result side is a queue read port: while empty is low the oldest result sits on
// code_unit/is_end_report/unit_count/end_status/terminator_fits/last and is taken
// at an edge with pop high. last marks the final result caused by one byte
// a byte leaves zero to three results; the first passes through the job queue
// and the output register to reach the result ports. the decoder handles one
// byte per cycle while full is low; the result side gives one result per cycle
// while pop is high, so bytes that expand to a surrogate pair or a report drain
// through a four-entry job queue and push sees full once it is filled
// when pop stays low the output register holds its result, the job queue fills
// and full rises; nothing is dropped
// cfg_wr_en writes capacity_units from cfg_wr_data in the same edge; write it
// only while no string is in flight
// reset clears the decoder state and both queues, capacity_units returns to 65535
module utf8_to_utf16_transcoder_unit
	import u8u16_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	output logic              full,
	input  logic [BYTE_W-1:0] data_byte,
	input  logic              end_of_string,
	input  logic              cfg_wr_en,
	input  logic [UNIT_W-1:0] cfg_wr_data,
	output logic              empty,
	input  logic              pop,
	output logic [UNIT_W-1:0] code_unit,
	output logic              is_end_report,
	output logic [UNIT_W-1:0] unit_count,
	output logic [1:0]        end_status,
	output logic              terminator_fits,
	output logic              last
);

	logic accept;
	logic job_valid;
	job_t job;
	logic head_valid;
	job_t head_job;
	logic head_pop;

	assign accept = push && !full;

	u8u16_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.accept        (accept),
		.data_byte     (data_byte),
		.end_of_string (end_of_string),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_wr_data   (cfg_wr_data),
		.job_valid     (job_valid),
		.job           (job)
	);

	u8u16_jobq u_jobq (
		.clk        (clk),
		.arst_n     (arst_n),
		.wr_en      (job_valid),
		.wr_job     (job),
		.full       (full),
		.rd_en      (head_pop),
		.head_valid (head_valid),
		.head_job   (head_job)
	);

	u8u16_back u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.head_valid      (head_valid),
		.head_job        (head_job),
		.head_pop        (head_pop),
		.pop             (pop),
		.empty           (empty),
		.code_unit       (code_unit),
		.is_end_report   (is_end_report),
		.unit_count      (unit_count),
		.end_status      (end_status),
		.terminator_fits (terminator_fits),
		.last            (last)
	);

endmodule
